### hdl/threshold_crossing_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the threshold crossing interpolator modules.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_CROSSING_INTERPOLATOR_CORE_DEFINES_SVH
`define THRESHOLD_CROSSING_INTERPOLATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_pkg
// Shared widths, register indexes and beat types of the crossing interpolator.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int TIME_BITS     = 32;
    localparam int VOLT_BITS     = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD     = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPORT_LEVELS = 1'd1;

    typedef struct packed {
        logic [TIME_BITS-1:0]        sample_time;
        logic signed [VOLT_BITS-1:0] sample_voltage;
        logic                        first_sample;
    } t_in;

    typedef struct packed {
        logic [TIME_BITS-1:0] crossing_time;
        logic                 level_after;
        logic                 initial_record;
        logic                 last_of_run;
    } t_out;

    // Work handed from the classifier to the record engine.
    typedef struct packed {
        logic                 flush;       // emit the held record first
        logic                 pend_level;  // level of the held record
        logic                 is_init;     // emit a time-zero record
        logic                 has_cross;   // interpolate a crossing
        logic                 defer;       // hold the crossing, level unknown yet
        logic                 rec_level;   // level of the initial or crossing record
        logic [TIME_BITS-1:0] prev_time;
        logic [TIME_BITS-1:0] dt;
        logic [VOLT_BITS-1:0] num;
        logic [VOLT_BITS-1:0] den;
    } t_cmd;

endpackage

### hdl/threshold_crossing_interpolator_core.sv
`timescale 1ns / 1ps
// Path: the classifier pushes a command into the queue; the engine pops it when idle
// and registers an initial or flushed record at once, or runs the serial divider
// (S_DIV) for a crossing; a held record goes out first (S_PEND).
// Throughput: one sample per cycle while the command queue has room; the engine takes
// one command at a time and pops the next only once it is back in S_IDLE.
// Reset (synchronous, active low) clears history, queue and engine; threshold 0, levels 1.
// ----------------------------------------------------------------------------
// threshold_crossing_interpolator_core
// Linear interpolated threshold crossing detector: classifier, command queue
// and record engine.
// ----------------------------------------------------------------------------
module threshold_crossing_interpolator_core #(
    parameter int QUEUE_DEPTH = tci_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tci_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tci_pkg::t_out                     o_out,
    input  logic                              i_cfg_we,
    input  logic [tci_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tci_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    tci_pkg::t_cmd w_cmd_in;
    tci_pkg::t_cmd w_cmd_out;

    tci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    tci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    tci_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### hdl/tci_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_front
// Holds configuration and the previous sample, classifies each input beat
// and pushes the resulting work into the command queue.
// ----------------------------------------------------------------------------
module tci_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tci_pkg::t_in                      i_in,
    input  logic                              i_cfg_we,
    input  logic [tci_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tci_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_full,
    output logic                              o_push,
    output tci_pkg::t_cmd                     o_cmd
);

    localparam int TB = tci_pkg::TIME_BITS;
    localparam int VB = tci_pkg::VOLT_BITS;

    logic signed [VB-1:0] r_threshold;
    logic                 r_report_levels;
    logic signed [VB-1:0] r_prev_v;
    logic [TB-1:0]        r_prev_t;
    logic                 r_have_prev;
    logic                 r_pend;

    logic signed [VB-1:0] w_v;
    logic [TB-1:0]        w_t;
    logic                 w_accept;
    logic                 w_start;
    logic                 w_cross;
    logic                 w_defer;
    logic                 w_gt_lvl;

    // Magnitude of a difference of two signed values; it always fits VB bits.
    function automatic logic [VB-1:0] abs_diff(input logic [VB-1:0] a,
                                               input logic [VB-1:0] b);
        logic [VB:0] d;
        d = {a[VB-1], a} - {b[VB-1], b};
        if (d[VB]) begin
            d = ~d + 1'b1;
        end
        return d[VB-1:0];
    endfunction

    assign w_v      = i_in.sample_voltage;
    assign w_t      = i_in.sample_time;
    assign o_in_ready = !i_full;
    assign w_accept = i_in_valid && !i_full;
    assign w_start  = i_in.first_sample || !r_have_prev;
    assign w_cross  = (r_prev_v < r_threshold) != (w_v < r_threshold);
    assign w_defer  = r_report_levels && (w_v == r_threshold);
    assign w_gt_lvl = r_report_levels && (w_v > r_threshold);

    always_comb begin
        o_cmd            = '0;
        o_cmd.flush      = r_pend;
        o_cmd.pend_level = w_start ? 1'b0 : w_gt_lvl;
        o_cmd.is_init    = w_start;
        o_cmd.has_cross  = !w_start && w_cross;
        o_cmd.defer      = w_defer;
        o_cmd.rec_level  = w_gt_lvl;
        o_cmd.prev_time  = r_prev_t;
        o_cmd.dt         = (w_t >= r_prev_t) ? (w_t - r_prev_t) : '0;
        o_cmd.num        = abs_diff(r_prev_v, r_threshold);
        o_cmd.den        = abs_diff(w_v, r_prev_v);
    end

    // Beats that cause no record and leave nothing to compute stay out of the queue.
    assign o_push = w_accept && (r_pend || w_start || w_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= '0;
            r_report_levels <= 1'b1;
            r_prev_v        <= '0;
            r_prev_t        <= '0;
            r_have_prev     <= 1'b0;
            r_pend          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tci_pkg::CFG_THRESHOLD: begin
                        r_threshold <= i_cfg_data[VB-1:0];
                    end
                    tci_pkg::CFG_REPORT_LEVELS: begin
                        r_report_levels <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_prev_v    <= w_v;
                r_prev_t    <= w_t;
                r_have_prev <= 1'b1;
                r_pend      <= !w_start && w_cross && w_defer;
            end
        end
    end

endmodule

### hdl/tci_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_queue
// Small first-in first-out buffer of commands between classifier and engine.
// ----------------------------------------------------------------------------
`include "threshold_crossing_interpolator_core_defines.svh"

module tci_queue #(
    parameter int DEPTH = tci_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tci_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tci_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    tci_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TCI_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")
    `TCI_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

### hdl/tci_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_back
// Record engine: emits held and initial records and interpolates crossing
// times with a bit-serial multiply-divide, one time bit per cycle.
// ----------------------------------------------------------------------------
`include "threshold_crossing_interpolator_core_defines.svh"

module tci_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tci_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tci_pkg::t_out o_out
);

    localparam int TB = tci_pkg::TIME_BITS;
    localparam int VB = tci_pkg::VOLT_BITS;
    localparam int RW = VB + 2;
    localparam int CW = $clog2(TB);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEND,
        S_DIV,
        S_OUT
    } t_state;

    t_state        r_state;
    tci_pkg::t_cmd r_cmd;
    tci_pkg::t_out r_out;
    logic          r_out_valid;
    logic [TB-1:0] r_pend_time;
    logic [TB-1:0] r_dt;
    logic [TB-1:0] r_q;
    logic [VB-1:0] r_rem;
    logic [CW-1:0] r_cnt;

    logic [RW-1:0] w_den;
    logic [RW-1:0] w_s0;
    logic [RW-1:0] w_s1;
    logic [RW-1:0] w_s2;
    logic          w_c1;
    logic          w_c2;
    logic [VB-1:0] n_rem;
    logic [TB-1:0] n_q;
    logic [TB-1:0] w_cross_time;

    // One step of remainder update: r = 2r + (bit ? num : 0), then reduce.
    // Since r < den and num <= den, two subtractions always suffice.
    always_comb begin
        w_den = {2'b00, r_cmd.den};
        w_s0  = {1'b0, r_rem, 1'b0} + (r_dt[TB-1] ? {2'b00, r_cmd.num} : '0);
        w_c1  = (w_s0 >= w_den);
        w_s1  = w_c1 ? (w_s0 - w_den) : w_s0;
        w_c2  = (w_s1 >= w_den);
        w_s2  = w_c2 ? (w_s1 - w_den) : w_s1;
        n_rem = w_s2[VB-1:0];
        n_q   = {r_q[TB-2:0], 1'b0} + TB'(w_c1) + TB'(w_c2);
        w_cross_time = r_cmd.prev_time + n_q;
    end

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.flush) begin
                            r_out.crossing_time  <= r_pend_time;
                            r_out.level_after    <= i_cmd.pend_level;
                            r_out.initial_record <= 1'b0;
                            r_out.last_of_run    <= !(i_cmd.is_init ||
                                                      (i_cmd.has_cross && !i_cmd.defer));
                            r_out_valid          <= 1'b1;
                            r_state              <= S_PEND;
                        end else if (i_cmd.is_init) begin
                            r_out.crossing_time  <= '0;
                            r_out.level_after    <= i_cmd.rec_level;
                            r_out.initial_record <= 1'b1;
                            r_out.last_of_run    <= 1'b1;
                            r_out_valid          <= 1'b1;
                            r_state              <= S_OUT;
                        end else begin
                            r_dt    <= i_cmd.dt;
                            r_q     <= '0;
                            r_rem   <= '0;
                            r_cnt   <= CW'(TB - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_PEND: begin
                    if (i_out_ready) begin
                        if (r_cmd.is_init) begin
                            r_out.crossing_time  <= '0;
                            r_out.level_after    <= r_cmd.rec_level;
                            r_out.initial_record <= 1'b1;
                            r_out.last_of_run    <= 1'b1;
                            r_state              <= S_OUT;
                        end else if (r_cmd.has_cross) begin
                            r_out_valid <= 1'b0;
                            r_dt        <= r_cmd.dt;
                            r_q         <= '0;
                            r_rem       <= '0;
                            r_cnt       <= CW'(TB - 1);
                            r_state     <= S_DIV;
                        end else begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_dt  <= {r_dt[TB-2:0], 1'b0};
                    r_q   <= n_q;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        if (r_cmd.defer) begin
                            // Level is known only once the next sample arrives.
                            r_pend_time <= w_cross_time;
                            r_state     <= S_IDLE;
                        end else begin
                            r_out.crossing_time  <= w_cross_time;
                            r_out.level_after    <= r_cmd.rec_level;
                            r_out.initial_record <= 1'b0;
                            r_out.last_of_run    <= 1'b1;
                            r_out_valid          <= 1'b1;
                            r_state              <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    `TCI_ASSERT_NOW(a_div_quiet, i_clk, i_rst_n, r_state == S_DIV, !r_out_valid, "result shown during division")
    `TCI_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_cmd.den, "remainder not below divisor")
    `TCI_ASSERT_NOW(a_init_zero, i_clk, i_rst_n, r_out_valid && r_out.initial_record, r_out.crossing_time == '0, "initial record with nonzero time")
    `TCI_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != S_IDLE, "engine idle after taking a command")

endmodule

### verif/tb_threshold_crossing_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_crossing_interpolator_core
// Self-checking bench for the crossing interpolator. A driver feeds sample
// beats from a backlog queue, a predictor works out the crossing records of
// every accepted sample, and a monitor compares each output beat with the
// oldest predicted record. Directed waveforms cover the threshold corners,
// random phases use five threshold and level-report settings.
// ----------------------------------------------------------------------------
module tb_threshold_crossing_interpolator_core;

    localparam int TIME_BITS     = tci_pkg::TIME_BITS;
    localparam int VOLT_BITS     = tci_pkg::VOLT_BITS;
    localparam int CFG_IDX_BITS  = tci_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = tci_pkg::CFG_DATA_BITS;

    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 45;

    typedef struct {
        tci_pkg::t_in beat;
        int           gap;
    } t_pending_sample;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    tci_pkg::t_in             in_beat   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    tci_pkg::t_out            out_beat;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Predictor copy of the configuration and the sample history.
    logic signed [VOLT_BITS-1:0] thr_reg;
    logic                        rep_lvl;
    logic signed [VOLT_BITS-1:0] prev_volt;
    logic [TIME_BITS-1:0]        prev_stamp;
    logic                        have_prev;
    logic                        held_valid;
    logic [TIME_BITS-1:0]        held_stamp;

    t_pending_sample sample_backlog[$];
    tci_pkg::t_out   expected_records[$];
    int              samples_sent  = 0;
    int              samples_taken = 0;
    int              mismatches    = 0;
    int              cycle_count   = 0;
    int              tx_waited     = 0;
    int              rx_wait       = 0;
    int              hold_left     = 0;
    logic            tx_idle       = 1'b0;
    logic            rx_idle       = 1'b0;
    logic            hold_req      = 1'b0;
    t_pending_sample next_sample;
    tci_pkg::t_out   want;

    threshold_crossing_interpolator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic tci_pkg::t_out make_record(logic [TIME_BITS-1:0] stamp, logic lvl,
                                                  logic init);
        tci_pkg::t_out rec;
        rec.crossing_time  = stamp;
        rec.level_after    = lvl;
        rec.initial_record = init;
        rec.last_of_run    = 1'b0;
        return rec;
    endfunction

    // Works out the records caused by one accepted sample and advances the history.
    function automatic void predict_records(tci_pkg::t_in s);
        tci_pkg::t_out        recs[3];
        int                   n;
        longint               v;
        longint               pv;
        longint               th;
        longint unsigned      num;
        longint unsigned      den;
        logic [TIME_BITS-1:0] dt;
        logic [TIME_BITS-1:0] stamp;
        logic                 above;
        n     = 0;
        v     = longint'($signed(s.sample_voltage));
        pv    = longint'(prev_volt);
        th    = longint'(thr_reg);
        above = rep_lvl && (v > th);
        if (s.first_sample || !have_prev) begin
            if (held_valid) begin
                recs[n] = make_record(held_stamp, 1'b0, 1'b0);
                n++;
                held_valid = 1'b0;
            end
            recs[n] = make_record('0, above, 1'b1);
            n++;
        end else begin
            if (held_valid) begin
                recs[n] = make_record(held_stamp, above, 1'b0);
                n++;
                held_valid = 1'b0;
            end
            if ((pv < th) != (v < th)) begin
                dt    = (s.sample_time >= prev_stamp) ? s.sample_time - prev_stamp : '0;
                num   = (pv >= th) ? longint'(pv - th) : longint'(th - pv);
                den   = (v >= pv) ? longint'(v - pv) : longint'(pv - v);
                stamp = prev_stamp + TIME_BITS'((num * 64'(dt)) / den);
                if (!rep_lvl) begin
                    recs[n] = make_record(stamp, 1'b0, 1'b0);
                    n++;
                end else if (v != th) begin
                    recs[n] = make_record(stamp, v > th, 1'b0);
                    n++;
                end else begin
                    // The level after a crossing that lands on the threshold is
                    // only known from the next sample.
                    held_valid = 1'b1;
                    held_stamp = stamp;
                end
            end
        end
        prev_volt  = s.sample_voltage;
        prev_stamp = s.sample_time;
        have_prev  = 1'b1;
        if (n > 0) recs[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++) expected_records = {expected_records, recs[k]};
    endfunction

    // Sender: one beat at a time, each after its own idle gap.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            tx_waited = 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                samples_taken++;
                predict_records(in_beat);
            end
            if (sample_backlog.size() > 0 && tx_waited >= sample_backlog[0].gap) begin
                next_sample = sample_backlog.pop_front();
                in_beat   <= next_sample.beat;
                in_valid  <= 1'b1;
                tx_waited = 0;
            end else begin
                if (sample_backlog.size() > 0) tx_waited++;
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each record beat and draws its own stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_records.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected record, expected none, got time=%0d level=%b",
                             $time, out_beat.crossing_time, out_beat.level_after,
                             " initial=%b last=%b", out_beat.initial_record,
                             out_beat.last_of_run);
                end else begin
                    want = expected_records.pop_front();
                    if (out_beat.crossing_time !== want.crossing_time ||
                        out_beat.level_after !== want.level_after ||
                        out_beat.initial_record !== want.initial_record ||
                        out_beat.last_of_run !== want.last_of_run) begin
                        mismatches++;
                        $display("%0t: record mismatch, expected time=%0d level=%b",
                                 $time, want.crossing_time, want.level_after,
                                 " initial=%b last=%b", want.initial_record,
                                 want.last_of_run);
                        $display("%0t: record mismatch, actual   time=%0d level=%b",
                                 $time, out_beat.crossing_time, out_beat.level_after,
                                 " initial=%b last=%b", out_beat.initial_record,
                                 out_beat.last_of_run);
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
            end
            if (hold_req) hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_sample(logic [TIME_BITS-1:0] stamp, int volts, logic first);
        t_pending_sample p;
        p.beat.sample_time    = stamp;
        p.beat.sample_voltage = VOLT_BITS'(volts);
        p.beat.first_sample   = first;
        p.gap                 = tx_idle ? $urandom_range(0, 8) : 0;
        sample_backlog = {sample_backlog, p};
        samples_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == tci_pkg::CFG_THRESHOLD) thr_reg = data[VOLT_BITS-1:0];
        else if (idx == tci_pkg::CFG_REPORT_LEVELS) rep_lvl = data[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Idle means every sample taken, every record seen, and the engine given
    // time to finish work that yields no record.
    task automatic wait_drained();
        while (samples_taken != samples_sent || expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Voltages cluster around the threshold so crossings and exact hits are common.
    function automatic int pick_voltage();
        int x;
        case ($urandom_range(0, 9))
            0, 1, 2: x = int'(thr_reg);
            3, 4, 5, 6: x = int'(thr_reg) + int'($urandom_range(0, 128)) - 64;
            7, 8: x = int'($urandom_range(0, 65535)) - 32768;
            default: x = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x;
    endfunction

    task automatic add_waveform(int len);
        logic [TIME_BITS-1:0] stamp;
        logic                 first;
        stamp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
        // A few waveforms carry on without a start marker.
        first = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < len; k++) begin
            queue_sample(stamp, pick_voltage(), first);
            first = 1'b0;
            case ($urandom_range(0, 19))
                0: stamp = stamp - $urandom_range(1, 50);
                1: stamp = stamp + $urandom;
                2: stamp = stamp;
                default: stamp = stamp + $urandom_range(1, 200);
            endcase
        end
    endtask

    task automatic run_random_phase(int thr, logic rep, logic long_stall);
        int start;
        write_reg(tci_pkg::CFG_THRESHOLD, CFG_DATA_BITS'(thr));
        write_reg(tci_pkg::CFG_REPORT_LEVELS, CFG_DATA_BITS'(rep));
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
        if (long_stall) begin
            @(posedge clk);
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        start = samples_sent;
        while (samples_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 6) == 0)
                queue_sample($urandom, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            else
                add_waveform($urandom_range(2, 16));
        end
        wait_drained();
    endtask

    initial begin
        thr_reg    = '0;
        rep_lvl    = 1'b1;
        prev_volt  = '0;
        prev_stamp = '0;
        have_prev  = 1'b0;
        held_valid = 1'b0;
        held_stamp = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: threshold 0, levels reported.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        queue_sample(0, 100, 1'b0);            // no waveform started yet
        queue_sample(10, -100, 1'b0);
        queue_sample(20, 0, 1'b0);             // lands on the threshold, held
        queue_sample(30, 50, 1'b0);            // completes the held record
        queue_sample(40, -32768, 1'b0);
        queue_sample(50, 0, 1'b0);
        queue_sample(0, 32767, 1'b1);          // new waveform flushes the held record
        queue_sample(32'hFFFF_FFFF, -32768, 1'b0);
        queue_sample(5, 32767, 1'b0);          // time runs backwards
        queue_sample(6, 0, 1'b0);
        queue_sample(7, -1, 1'b0);
        queue_sample(8, 0, 1'b0);              // held across the next register write
        wait_drained();

        write_reg(tci_pkg::CFG_REPORT_LEVELS, CFG_DATA_BITS'(0));
        queue_sample(9, -5, 1'b0);
        queue_sample(20, 0, 1'b0);
        queue_sample(30, -7, 1'b0);
        wait_drained();

        write_reg(tci_pkg::CFG_THRESHOLD, CFG_DATA_BITS'(32767));
        queue_sample(0, 32767, 1'b1);
        queue_sample(100, -32768, 1'b0);
        queue_sample(200, 32767, 1'b0);
        wait_drained();

        write_reg(tci_pkg::CFG_THRESHOLD, CFG_DATA_BITS'(-32768));
        write_reg(tci_pkg::CFG_REPORT_LEVELS, CFG_DATA_BITS'(1));
        queue_sample(0, -32768, 1'b1);
        queue_sample(10, 32767, 1'b0);
        queue_sample(20, -32768, 1'b0);
        queue_sample(1, -32767, 1'b1);
        wait_drained();

        run_random_phase(0, 1'b1, 1'b0);
        run_random_phase(int'($urandom_range(0, 65535)) - 32768, 1'b0, 1'b0);
        run_random_phase(int'($urandom_range(0, 400)) - 200, 1'b1, 1'b1);
        run_random_phase(32767, 1'b1, 1'b0);
        run_random_phase(-32768, 1'b0, 1'b0);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/tci_pkg.sv
hdl/tci_front.sv
hdl/tci_queue.sv
hdl/tci_back.sv
hdl/threshold_crossing_interpolator_core.sv
verif/tb_threshold_crossing_interpolator_core.sv
